>>> sv/byte_ring_fifo_unit_assert.svh
// Assertion macros shared by the byte ring FIFO modules.
// No dependencies; taken in by `include where assertions are written.
`ifndef BYTE_RING_FIFO_UNIT_ASSERT_SVH
`define BYTE_RING_FIFO_UNIT_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define BRF_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define BRF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/brf_pkg.sv
// Package of the byte ring FIFO: field widths, defaults, opcodes, controller types.
// No dependencies.
package brf_pkg;

   localparam int DEPTH_DEFAULT     = 256;
   localparam int MAX_BURST_DEFAULT = 16;

   localparam int OPCODE_W = 3;
   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 9;
   localparam int LEVEL_W  = 9;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUT        = 3'd0,
      OP_READ       = 3'd1,
      OP_PEEK       = 3'd2,
      OP_DISCARD    = 3'd3,
      OP_RESET_ALL  = 3'd4,
      OP_RESET_READ = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_BURST
   } state_type;

   typedef struct packed {
      logic req_ready;
      logic accept;
      logic step;
      logic rsp_valid;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic rsp_ready;
      logic burst_start;
      logic burst_last;
   } ctrl_status_type;

endpackage

>>> sv/brf_req_if.sv
// Request channel of the byte ring FIFO: handshake and operation fields.
// Depends on brf_pkg for the field widths.
interface brf_req_if;
   logic                          valid;
   logic                          ready;
   logic [brf_pkg::OPCODE_W-1:0]  opcode;
   logic [brf_pkg::BYTE_W-1:0]    data_byte;
   logic [brf_pkg::COUNT_W-1:0]   count;

   modport source (output valid, output opcode, output data_byte, output count,
                   input ready);
   modport sink   (input valid, input opcode, input data_byte, input count,
                   output ready);
endinterface

>>> sv/brf_rsp_if.sv
// Response channel of the byte ring FIFO: handshake and result fields.
// Depends on brf_pkg for the field widths.
interface brf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [brf_pkg::BYTE_W-1:0]    out_byte;
   logic                          byte_valid;
   logic [brf_pkg::LEVEL_W-1:0]   moved;
   logic [brf_pkg::LEVEL_W-1:0]   fill_level;
   logic [brf_pkg::LEVEL_W-1:0]   free_space;
   logic                          last;

   modport source (output valid, output out_byte, output byte_valid, output moved,
                   output fill_level, output free_space, output last, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input moved,
                   input fill_level, input free_space, input last, output ready);
endinterface

>>> sv/brf_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/brf_ctrl.sv
// Controller of the byte ring FIFO: takes a transaction, then presents one
// result or a burst of byte results. Depends on brf_pkg.
module brf_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  brf_pkg::ctrl_status_type status,
   output brf_pkg::ctrl_cmd_type    cmd
);

   brf_pkg::state_type state_ff;
   brf_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      unique case (state_ff)
         brf_pkg::ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (status.req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.burst_start ? brf_pkg::ST_BURST : brf_pkg::ST_SINGLE;
            end
         end
         brf_pkg::ST_SINGLE: begin
            cmd.rsp_valid = 1'b1;
            if (status.rsp_ready) begin
               state_in = brf_pkg::ST_IDLE;
            end
         end
         brf_pkg::ST_BURST: begin
            cmd.rsp_valid = 1'b1;
            if (status.rsp_ready) begin
               if (status.burst_last) begin
                  state_in = brf_pkg::ST_IDLE;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         default: begin
            state_in = brf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> sv/brf_datapath.sv
// Datapath of the byte ring FIFO: ring indices, byte store, burst counter and
// result registers. Depends on brf_pkg, brf_ram and the assertion macros.
`include "byte_ring_fifo_unit_assert.svh"

module brf_datapath #(
   parameter int DEPTH     = brf_pkg::DEPTH_DEFAULT,
   parameter int MAX_BURST = brf_pkg::MAX_BURST_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  brf_pkg::ctrl_cmd_type        cmd,
   output brf_pkg::ctrl_status_type     status,
   input  logic                         req_valid,
   input  logic [brf_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [brf_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic [brf_pkg::COUNT_W-1:0]  req_count,
   input  logic                         rsp_ready,
   output logic [brf_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                         rsp_byte_valid,
   output logic [brf_pkg::LEVEL_W-1:0]  rsp_moved,
   output logic [brf_pkg::LEVEL_W-1:0]  rsp_fill_level,
   output logic [brf_pkg::LEVEL_W-1:0]  rsp_free_space,
   output logic                         rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int IW = AW + 1;
   localparam int BW = $clog2(MAX_BURST + 1);
   localparam int CW = (IW > BW) ? IW : BW;
   localparam int DW = (IW > brf_pkg::COUNT_W) ? IW : brf_pkg::COUNT_W;
   localparam logic [IW-1:0] DEPTH_IDX = IW'(DEPTH);
   localparam logic [BW-1:0] BURST_MAX = BW'(MAX_BURST);

   logic [IW-1:0] wr_idx_ff, wr_idx_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic [IW-1:0] addr_ff, addr_in;
   logic [BW-1:0] remain_ff, remain_in;
   logic          byte_valid_ff, byte_valid_in;
   logic [brf_pkg::LEVEL_W-1:0] moved_ff, moved_in;
   logic [brf_pkg::LEVEL_W-1:0] fill_ff, fill_in;
   logic [brf_pkg::LEVEL_W-1:0] free_ff, free_in;

   logic [IW-1:0] fill_now;
   logic [IW-1:0] fill_after;
   logic          full;
   logic [BW-1:0] cnt_clamp;
   logic [BW-1:0] n_burst;
   logic [IW-1:0] n_disc;
   logic          is_burst_op;
   logic          ram_wr_en;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [brf_pkg::BYTE_W-1:0] ram_rd_data;

   assign fill_now  = wr_idx_ff - rd_idx_ff;
   assign full      = (fill_now == DEPTH_IDX);
   assign cnt_clamp = (req_count > brf_pkg::COUNT_W'(MAX_BURST)) ? BURST_MAX
                                                                 : BW'(req_count);
   assign n_burst   = (CW'(cnt_clamp) > CW'(fill_now)) ? BW'(fill_now) : cnt_clamp;
   assign n_disc    = (DW'(req_count) > DW'(fill_now)) ? fill_now : IW'(req_count);

   assign is_burst_op = (req_opcode == brf_pkg::OP_READ) ||
                        (req_opcode == brf_pkg::OP_PEEK);

   assign status.req_valid   = req_valid;
   assign status.rsp_ready   = rsp_ready;
   assign status.burst_start = is_burst_op && (n_burst != '0);
   assign status.burst_last  = (remain_ff == BW'(1));

   always_comb begin
      wr_idx_in     = wr_idx_ff;
      rd_idx_in     = rd_idx_ff;
      addr_in       = addr_ff;
      remain_in     = remain_ff;
      byte_valid_in = byte_valid_ff;
      moved_in      = moved_ff;
      fill_in       = fill_ff;
      free_in       = free_ff;
      fill_after    = fill_now;
      ram_wr_en     = 1'b0;
      if (cmd.accept) begin
         byte_valid_in = 1'b0;
         moved_in      = '0;
         remain_in     = '0;
         addr_in       = rd_idx_ff + IW'(1);
         unique case (req_opcode)
            brf_pkg::OP_PUT: begin
               if (!full) begin
                  ram_wr_en  = 1'b1;
                  wr_idx_in  = wr_idx_ff + IW'(1);
                  fill_after = fill_now + IW'(1);
                  moved_in   = brf_pkg::LEVEL_W'(1);
               end
            end
            brf_pkg::OP_READ: begin
               rd_idx_in     = rd_idx_ff + IW'(n_burst);
               fill_after    = fill_now - IW'(n_burst);
               byte_valid_in = (n_burst != '0);
               remain_in     = n_burst;
            end
            brf_pkg::OP_PEEK: begin
               byte_valid_in = (n_burst != '0);
               remain_in     = n_burst;
            end
            brf_pkg::OP_DISCARD: begin
               rd_idx_in  = rd_idx_ff + n_disc;
               fill_after = fill_now - n_disc;
               moved_in   = brf_pkg::LEVEL_W'(n_disc);
            end
            brf_pkg::OP_RESET_ALL: begin
               wr_idx_in  = '0;
               rd_idx_in  = '0;
               fill_after = '0;
            end
            brf_pkg::OP_RESET_READ: begin
               rd_idx_in  = wr_idx_ff;
               fill_after = '0;
            end
            default: begin
               fill_after = fill_now;
            end
         endcase
         fill_in = brf_pkg::LEVEL_W'(fill_after);
         free_in = brf_pkg::LEVEL_W'(DEPTH_IDX - fill_after);
      end else if (cmd.step) begin
         addr_in   = addr_ff + IW'(1);
         remain_in = remain_ff - BW'(1);
      end
   end

   assign ram_rd_en   = (cmd.accept && is_burst_op) || cmd.step;
   assign ram_rd_addr = cmd.accept ? rd_idx_ff[AW-1:0] : addr_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff     <= '0;
         rd_idx_ff     <= '0;
         remain_ff     <= '0;
         byte_valid_ff <= 1'b0;
      end else begin
         wr_idx_ff     <= wr_idx_in;
         rd_idx_ff     <= rd_idx_in;
         remain_ff     <= remain_in;
         byte_valid_ff <= byte_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      moved_ff <= moved_in;
      fill_ff  <= fill_in;
      free_ff  <= free_in;
   end

   brf_ram #(
      .WIDTH (brf_pkg::BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_idx_ff[AW-1:0]),
      .wr_data (req_data_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_out_byte   = byte_valid_ff ? ram_rd_data : '0;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_moved      = moved_ff;
   assign rsp_fill_level = fill_ff;
   assign rsp_free_space = free_ff;
   assign rsp_last       = byte_valid_ff ? (remain_ff == BW'(1)) : 1'b1;

   `BRF_ASSERT_ALWAYS(a_fill_bounded, clock, reset, fill_now <= DEPTH_IDX, "fill exceeds depth")
   `BRF_ASSERT_IMPLY(a_burst_has_bytes, clock, reset, byte_valid_ff, remain_ff != '0, "empty burst")
   `BRF_ASSERT_IMPLY(a_step_not_last, clock, reset, cmd.step, remain_ff > BW'(1), "step past end")
   `BRF_ASSERT_NEXT(a_put_advances, clock, reset, cmd.accept && ram_wr_en, wr_idx_ff == $past(wr_idx_ff) + 1'b1, "put lost")

endmodule

>>> sv/byte_ring_fifo_unit.sv
// Top level of the byte ring FIFO: controller, datapath and channel wiring.
// Depends on brf_pkg, brf_req_if, brf_rsp_if, brf_ctrl and brf_datapath.
//
//   Channel   Direction  Handshake      Carries
//   req_bus   in         valid/ready    opcode, data_byte, count
//   rsp_bus   out        valid/ready    out_byte, byte_valid, moved, levels, last
//
// A transaction is taken when valid meets ready, and its result is held in a
// register from the next cycle on. A read or peek presents one byte per cycle
// while the response is taken, from the single read port of the store, whose
// read data is registered.
// Reset is synchronous and empties the FIFO at once; the store needs no clearing.
// A stalled response holds the block; no new request is taken until the
// last result of the current one has been taken.
module byte_ring_fifo_unit #(
   parameter int DEPTH     = brf_pkg::DEPTH_DEFAULT,
   parameter int MAX_BURST = brf_pkg::MAX_BURST_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   brf_req_if.sink   req_bus,
   brf_rsp_if.source rsp_bus
);

   brf_pkg::ctrl_cmd_type    cmd;
   brf_pkg::ctrl_status_type status;

   brf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   brf_datapath #(
      .DEPTH     (DEPTH),
      .MAX_BURST (MAX_BURST)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_valid      (req_bus.valid),
      .req_opcode     (req_bus.opcode),
      .req_data_byte  (req_bus.data_byte),
      .req_count      (req_bus.count),
      .rsp_ready      (rsp_bus.ready),
      .rsp_out_byte   (rsp_bus.out_byte),
      .rsp_byte_valid (rsp_bus.byte_valid),
      .rsp_moved      (rsp_bus.moved),
      .rsp_fill_level (rsp_bus.fill_level),
      .rsp_free_space (rsp_bus.free_space),
      .rsp_last       (rsp_bus.last)
   );

   assign req_bus.ready = cmd.req_ready;
   assign rsp_bus.valid = cmd.rsp_valid;

endmodule

>>> dv/tb.sv
// Self-checking testbench of byte_ring_fifo_unit: directed corners, fill and wrap,
// output back-pressure and random traffic, all checked against a ring FIFO predictor.
// Depends on brf_pkg, brf_req_if, brf_rsp_if and the byte_ring_fifo_unit RTL.
module tb;

   localparam int DEPTH       = brf_pkg::DEPTH_DEFAULT;
   localparam int MAX_BURST   = brf_pkg::MAX_BURST_DEFAULT;
   localparam int OPCODE_W    = brf_pkg::OPCODE_W;
   localparam int BYTE_W      = brf_pkg::BYTE_W;
   localparam int COUNT_W     = brf_pkg::COUNT_W;
   localparam int LEVEL_W     = brf_pkg::LEVEL_W;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int IDX_W       = ADDR_W + 1;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic               byte_valid;
      logic [LEVEL_W-1:0] moved;
      logic [LEVEL_W-1:0] fill_level;
      logic [LEVEL_W-1:0] free_space;
      logic               last;
   } fifo_result_type;

   logic clock = 1'b0;
   logic reset;

   brf_req_if req_bus ();
   brf_rsp_if rsp_bus ();

   byte_ring_fifo_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #2 clock = ~clock;

   logic [IDX_W-1:0]  shadow_wr_ptr = '0;
   logic [IDX_W-1:0]  shadow_rd_ptr = '0;
   logic [BYTE_W-1:0] shadow_store [DEPTH];
   fifo_result_type   pending_results [$];

   int unsigned error_count       = 0;
   int unsigned result_count      = 0;
   int unsigned quiet_cycles      = 0;
   int unsigned sink_hold_request = 0;
   bit          source_idle_on    = 1'b1;
   bit          sink_idle_on      = 1'b1;

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   function automatic void queue_fifo_result(input logic [BYTE_W-1:0] data_out,
                                             input logic data_ok,
                                             input logic [LEVEL_W-1:0] moved_bytes,
                                             input logic is_last);
      fifo_result_type  r;
      logic [IDX_W-1:0] level;
      level        = shadow_wr_ptr - shadow_rd_ptr;
      r.out_byte   = data_out;
      r.byte_valid = data_ok;
      r.moved      = moved_bytes;
      r.fill_level = LEVEL_W'(level);
      r.free_space = LEVEL_W'(DEPTH - level);
      r.last       = is_last;
      pending_results.push_back(r);
   endfunction

   // Levels in every result are taken after the whole operation has been applied.
   function automatic void predict_fifo_op(input logic [OPCODE_W-1:0] op,
                                           input logic [BYTE_W-1:0] payload,
                                           input logic [COUNT_W-1:0] amount);
      logic [IDX_W-1:0] level;
      logic [IDX_W-1:0] start;
      logic [IDX_W-1:0] pos;
      int unsigned      n;
      int unsigned      i;
      level = shadow_wr_ptr - shadow_rd_ptr;
      n     = 32'(amount);
      case (op)
         brf_pkg::OP_PUT: begin
            if (level < DEPTH) begin
               shadow_store[shadow_wr_ptr[ADDR_W-1:0]] = payload;
               shadow_wr_ptr = shadow_wr_ptr + 1'b1;
               queue_fifo_result('0, 1'b0, LEVEL_W'(1), 1'b1);
            end else begin
               queue_fifo_result('0, 1'b0, '0, 1'b1);
            end
         end
         brf_pkg::OP_READ, brf_pkg::OP_PEEK: begin
            if (n > MAX_BURST) n = MAX_BURST;
            if (n > level) n = 32'(level);
            if (n == 0) begin
               queue_fifo_result('0, 1'b0, '0, 1'b1);
            end else begin
               start = shadow_rd_ptr;
               if (op == brf_pkg::OP_READ) shadow_rd_ptr = shadow_rd_ptr + IDX_W'(n);
               for (i = 0; i < n; i++) begin
                  pos = start + IDX_W'(i);
                  queue_fifo_result(shadow_store[pos[ADDR_W-1:0]], 1'b1, '0, (i + 1 == n));
               end
            end
         end
         brf_pkg::OP_DISCARD: begin
            if (n > level) n = 32'(level);
            shadow_rd_ptr = shadow_rd_ptr + IDX_W'(n);
            queue_fifo_result('0, 1'b0, LEVEL_W'(n), 1'b1);
         end
         brf_pkg::OP_RESET_ALL: begin
            shadow_wr_ptr = '0;
            shadow_rd_ptr = '0;
            queue_fifo_result('0, 1'b0, '0, 1'b1);
         end
         brf_pkg::OP_RESET_READ: begin
            shadow_rd_ptr = shadow_wr_ptr;
            queue_fifo_result('0, 1'b0, '0, 1'b1);
         end
         default: begin
            queue_fifo_result('0, 1'b0, '0, 1'b1);
         end
      endcase
   endfunction

   task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] payload,
                          input logic [COUNT_W-1:0] amount);
      int unsigned gap;
      gap = source_idle_on ? $urandom_range(12, 0) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.opcode    <= op;
      req_bus.data_byte <= payload;
      req_bus.count     <= amount;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_fifo_op(op, payload, amount);
   endtask

   // The sender stops offering while it waits, so that no transaction is taken twice.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic test_directed_corners();
      send_op(brf_pkg::OP_READ, 8'h00, 9'd0);
      send_op(brf_pkg::OP_PEEK, 8'hFF, 9'd7);
      send_op(brf_pkg::OP_DISCARD, 8'h00, 9'd256);
      send_op(OP_SPARE_6, 8'hFF, 9'd256);
      send_op(brf_pkg::OP_PUT, 8'h00, 9'd0);
      send_op(brf_pkg::OP_PUT, 8'hFF, 9'd511);
      send_op(brf_pkg::OP_PUT, 8'h5A, 9'd3);
      send_op(brf_pkg::OP_PEEK, 8'h00, 9'd0);
      send_op(brf_pkg::OP_PEEK, 8'h00, 9'd256);
      send_op(brf_pkg::OP_READ, 8'h00, 9'd2);
      send_op(brf_pkg::OP_DISCARD, 8'h00, 9'd256);
      send_op(brf_pkg::OP_PUT, 8'h81, 9'd0);
      send_op(brf_pkg::OP_PUT, 8'h7E, 9'd0);
      send_op(brf_pkg::OP_RESET_READ, 8'h00, 9'd0);
      send_op(brf_pkg::OP_PUT, 8'h33, 9'd0);
      send_op(brf_pkg::OP_RESET_ALL, 8'h00, 9'd0);
      send_op(OP_SPARE_7, 8'h00, 9'd0);
      send_op(brf_pkg::OP_READ, 8'h00, 9'd1);
      send_op(brf_pkg::OP_PUT, 8'hC3, 9'd0);
      send_op(brf_pkg::OP_DISCARD, 8'h00, 9'd0);
      send_op(brf_pkg::OP_READ, 8'h00, 9'd16);
      wait_drained();
   endtask

   // One fill past the store size carries the write index across the end of the store
   // and tries a put into a full store.
   task automatic test_fill_and_wrap();
      int unsigned i;
      for (i = 0; i < DEPTH + 1; i++) begin
         send_op(brf_pkg::OP_PUT, BYTE_W'($urandom_range(255, 0)),
                 COUNT_W'($urandom_range(256, 0)));
      end
      send_op(brf_pkg::OP_PEEK, BYTE_W'($urandom_range(255, 0)), COUNT_W'(MAX_BURST + 1));
      send_op(brf_pkg::OP_READ, BYTE_W'($urandom_range(255, 0)), 9'd256);
      send_op(brf_pkg::OP_DISCARD, BYTE_W'($urandom_range(255, 0)), 9'd256);
      wait_drained();
   endtask

   task automatic test_output_backpressure();
      int unsigned i;
      source_idle_on    = 1'b0;
      sink_hold_request = HOLD_CYCLES;
      for (i = 0; i < 12; i++) begin
         if (i % 4 == 3) begin
            send_op(brf_pkg::OP_READ, BYTE_W'($urandom_range(255, 0)), COUNT_W'(MAX_BURST));
         end else begin
            send_op(brf_pkg::OP_PUT, BYTE_W'($urandom_range(255, 0)),
                    COUNT_W'($urandom_range(256, 0)));
         end
      end
      source_idle_on = 1'b1;
      wait_drained();
   endtask

   task automatic test_random_traffic(input int unsigned n_items);
      int unsigned          sent;
      int unsigned          run;
      int unsigned          kind;
      int unsigned          amount;
      logic [OPCODE_W-1:0]  op;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(7, 0) == 0) source_idle_on = !source_idle_on;
         if ($urandom_range(7, 0) == 0) sink_idle_on = !sink_idle_on;
         kind = $urandom_range(9, 0);
         case (kind)
            0, 1, 2: begin
               run = $urandom_range(8, 1);
               repeat (run) send_op(brf_pkg::OP_PUT, BYTE_W'($urandom_range(255, 0)),
                                    COUNT_W'($urandom_range(256, 0)));
               sent += run;
            end
            3, 4: begin
               amount = ($urandom_range(7, 0) == 0) ? $urandom_range(256, 17)
                                                    : $urandom_range(20, 0);
               send_op(brf_pkg::OP_READ, BYTE_W'($urandom_range(255, 0)), COUNT_W'(amount));
               sent++;
            end
            5: begin
               amount = $urandom_range(MAX_BURST, 1);
               send_op(brf_pkg::OP_PEEK, BYTE_W'($urandom_range(255, 0)), COUNT_W'(amount));
               send_op(brf_pkg::OP_READ, BYTE_W'($urandom_range(255, 0)), COUNT_W'(amount));
               sent += 2;
            end
            6: begin
               amount = ($urandom_range(3, 0) == 0) ? $urandom_range(256, 0)
                                                    : $urandom_range(8, 0);
               send_op(brf_pkg::OP_DISCARD, BYTE_W'($urandom_range(255, 0)),
                       COUNT_W'(amount));
               sent++;
            end
            7: begin
               wait_drained();
               send_op(brf_pkg::OP_PUT, BYTE_W'($urandom_range(255, 0)),
                       COUNT_W'($urandom_range(256, 0)));
               sent++;
            end
            default: begin
               op = OPCODE_W'($urandom_range(7, 0));
               if (op == brf_pkg::OP_RESET_ALL && $urandom_range(3, 0) != 0) begin
                  op = brf_pkg::OP_RESET_READ;
               end
               send_op(op, BYTE_W'($urandom_range(255, 0)), COUNT_W'($urandom_range(256, 0)));
               sent++;
            end
         endcase
      end
      source_idle_on = 1'b1;
      sink_idle_on   = 1'b1;
   endtask

   initial begin : result_sink
      int unsigned stall;
      forever begin
         stall = sink_idle_on ? $urandom_range(12, 0) : 0;
         if (sink_hold_request != 0) begin
            stall             = sink_hold_request;
            sink_hold_request = 0;
         end
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
      end
   end

   task automatic check_field(input string name, input logic [LEVEL_W-1:0] got,
                              input logic [LEVEL_W-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                   result_count, name, got, want));
      end
   endtask

   always @(posedge clock) begin : result_check
      fifo_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         result_count++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected",
                                      result_count));
         end else begin
            want = pending_results.pop_front();
            check_field("out_byte", LEVEL_W'(rsp_bus.out_byte), LEVEL_W'(want.out_byte));
            check_field("byte_valid", LEVEL_W'(rsp_bus.byte_valid),
                        LEVEL_W'(want.byte_valid));
            check_field("moved", rsp_bus.moved, want.moved);
            check_field("fill_level", rsp_bus.fill_level, want.fill_level);
            check_field("free_space", rsp_bus.free_space, want.free_space);
            check_field("last", LEVEL_W'(rsp_bus.last), LEVEL_W'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("byte_ring_fifo_unit regression: fail");
            $finish;
         end
      end
   end

   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.opcode    <= brf_pkg::OP_PUT;
      req_bus.data_byte <= '0;
      req_bus.count     <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_fill_and_wrap();
      test_output_backpressure();
      test_random_traffic(30);
      wait_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("byte_ring_fifo_unit regression: pass");
      end else begin
         $display("byte_ring_fifo_unit regression: fail");
      end
      $finish;
   end
endmodule
